>>> rtl/core/pscan_pkg.sv
// Shared types, codes and default sizes for the parity scanline fill core.
package pscan_pkg;

	// Default frame geometry and pixel width.
	localparam int FRAME_WIDTH_DEF  = 256;
	localparam int FRAME_HEIGHT_DEF = 256;
	localparam int COLOR_BITS_DEF   = 8;

	// Fixed field widths of the ports.
	localparam int REQ_W     = 2;
	localparam int COORD_W   = 8;
	localparam int COLOR_W   = 8;
	localparam int BOX_W     = 9;
	localparam int CODE_W    = 8;
	localparam int CFG_IDX_W = 1;

	// Request type codes.
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FILL  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OUTLINE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

	// Controller states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_WRITE,
		ST_READ,
		ST_ROW_START,
		ST_FILL_FIRST,
		ST_FILL_READ,
		ST_FILL_EVAL,
		ST_ROW_END,
		ST_REPAINT,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic clear_step;
		logic pix_write;
		logic pix_read;
		logic fill_init;
		logic row_start;
		logic fill_first;
		logic fill_read;
		logic fill_eval;
		logic row_end;
		logic repaint;
		logic next_row;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             clear_last;
		logic [REQ_W-1:0] req_type;
		logic             fill_go;
		logic             x_last;
		logic             parity;
		logic             repaint_last;
		logic             row_last;
		logic             out_free;
	} status_t;

endpackage

>>> rtl/core/pscan_dp.sv
// Datapath of the fill core: frame memory, request registers, walk counters and result register.
module pscan_dp #(
	parameter int FRAME_WIDTH  = pscan_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = pscan_pkg::FRAME_HEIGHT_DEF,
	parameter int COLOR_BITS   = pscan_pkg::COLOR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pscan_pkg::cmd_t                 cmd,
	output pscan_pkg::status_t              status,
	input  logic                            cfg_valid,
	input  logic [pscan_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pscan_pkg::CODE_W-1:0]    cfg_data,
	input  logic [pscan_pkg::REQ_W-1:0]     req_type,
	input  logic [pscan_pkg::COORD_W-1:0]   pixel_x,
	input  logic [pscan_pkg::COORD_W-1:0]   pixel_y,
	input  logic [pscan_pkg::COLOR_W-1:0]   color_value,
	input  logic [pscan_pkg::BOX_W-1:0]     box_left,
	input  logic [pscan_pkg::BOX_W-1:0]     box_right,
	input  logic [pscan_pkg::BOX_W-1:0]     box_top,
	input  logic [pscan_pkg::BOX_W-1:0]     box_bottom,
	input  logic                            outline_closed,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [pscan_pkg::COLOR_W-1:0]   read_color
);

	localparam int XW    = $clog2(FRAME_WIDTH);
	localparam int YW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
	localparam int AW    = XW + YW;
	localparam int DEPTH = FRAME_HEIGHT * (2 ** XW);
	// Walk coordinates need one bit more than the box fields.
	localparam int WW    = pscan_pkg::BOX_W + 1;

	// Pixel lies inside the frame.
	function automatic logic in_frame(input logic [WW-1:0] x, input logic [WW-1:0] y);
		in_frame = (32'(x) < 32'(FRAME_WIDTH)) && (32'(y) < 32'(FRAME_HEIGHT));
	endfunction

	// Row-major address with each row padded to a power of two.
	function automatic logic [AW-1:0] pix_addr(input logic [WW-1:0] x, input logic [WW-1:0] y);
		pix_addr = {YW'(y), XW'(x)};
	endfunction

	logic [COLOR_BITS-1:0]         mem [DEPTH];
	logic [COLOR_BITS-1:0]         mem_q;
	logic                          rd_oob_q;
	logic [AW-1:0]                 clr_q;
	logic [pscan_pkg::CODE_W-1:0]  outline_q;
	logic [pscan_pkg::CODE_W-1:0]  background_q;
	logic [pscan_pkg::REQ_W-1:0]   type_q;
	logic [pscan_pkg::COORD_W-1:0] px_q;
	logic [pscan_pkg::COORD_W-1:0] py_q;
	logic [pscan_pkg::COLOR_W-1:0] color_q;
	logic [pscan_pkg::BOX_W-1:0]   left_q;
	logic [pscan_pkg::BOX_W-1:0]   right_q;
	logic [pscan_pkg::BOX_W-1:0]   top_q;
	logic [pscan_pkg::BOX_W-1:0]   bottom_q;
	logic                          closed_q;
	logic [WW-1:0]                 x_q;
	logic [WW-1:0]                 y_q;
	logic [COLOR_BITS-1:0]         cur_q;
	logic                          inside_q;
	logic [pscan_pkg::BOX_W-1:0]   entry_q;
	logic                          out_valid_q;
	logic [pscan_pkg::COLOR_W-1:0] read_color_q;

	logic [COLOR_BITS-1:0] outl_m;
	logic [COLOR_BITS-1:0] back_m;
	logic [COLOR_BITS-1:0] fill_m;
	logic [COLOR_BITS-1:0] rdval;
	logic [WW-1:0]         x_next;
	logic                  toggle;
	logic                  rd_en;
	logic [WW-1:0]         rd_x;
	logic [WW-1:0]         rd_y;
	logic                  wr_en;
	logic [WW-1:0]         wr_x;
	logic [WW-1:0]         wr_y;
	logic [AW-1:0]         wr_addr;
	logic [COLOR_BITS-1:0] wr_data;

	// Colour codes at the stored pixel width.
	assign outl_m = COLOR_BITS'(outline_q);
	assign back_m = COLOR_BITS'(background_q);
	assign fill_m = COLOR_BITS'(color_q);

	// Pixel read back from memory; outside the frame it is background.
	assign rdval  = rd_oob_q ? back_m : mem_q;
	assign x_next = x_q + WW'(1);
	assign toggle = (cur_q == outl_m) && (rdval == back_m);

	// Read port selection.
	always_comb begin
		rd_en = cmd.pix_read | cmd.row_start | cmd.fill_first | cmd.fill_read;
		rd_y  = y_q;
		if (cmd.pix_read) begin
			rd_x = WW'(px_q);
			rd_y = WW'(py_q);
		end else if (cmd.row_start) begin
			rd_x = WW'(left_q);
		end else begin
			rd_x = x_next;
		end
	end

	// Write port selection.
	always_comb begin
		wr_x    = x_q;
		wr_y    = y_q;
		wr_data = fill_m;
		wr_en   = 1'b0;
		if (cmd.pix_write) begin
			wr_x  = WW'(px_q);
			wr_y  = WW'(py_q);
			wr_en = in_frame(WW'(px_q), WW'(py_q));
		end else if (cmd.fill_eval) begin
			wr_en = in_frame(x_q, y_q) && !toggle && (cur_q == back_m) && inside_q;
		end else if (cmd.repaint) begin
			wr_data = back_m;
			wr_en   = in_frame(x_q, y_q);
		end
		wr_addr = pix_addr(wr_x, wr_y);
		if (cmd.clear_step) begin
			wr_addr = clr_q;
			wr_data = '0;
			wr_en   = 1'b1;
		end
	end

	// Frame memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q    <= mem[pix_addr(rd_x, rd_y)];
			rd_oob_q <= !in_frame(rd_x, rd_y);
		end
	end

	// Configuration registers and clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outline_q    <= pscan_pkg::CODE_W'(1);
			background_q <= '0;
			clr_q        <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					pscan_pkg::CFG_OUTLINE:    outline_q    <= cfg_data;
					pscan_pkg::CFG_BACKGROUND: background_q <= cfg_data;
				endcase
			end
			if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Request fields captured when an item is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q   <= req_type;
			px_q     <= pixel_x;
			py_q     <= pixel_y;
			color_q  <= color_value;
			left_q   <= box_left;
			right_q  <= box_right;
			top_q    <= box_top;
			bottom_q <= box_bottom;
			closed_q <= outline_closed;
		end
	end

	// Scanline walk: column, row, current pixel, parity and entry column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			inside_q <= 1'b0;
			entry_q  <= '0;
		end else begin
			if (cmd.fill_init) begin
				y_q <= WW'(top_q);
			end
			if (cmd.row_start) begin
				x_q      <= WW'(left_q);
				inside_q <= 1'b0;
			end
			if (cmd.fill_eval) begin
				x_q <= x_next;
				if (toggle) begin
					inside_q <= ~inside_q;
					entry_q  <= pscan_pkg::BOX_W'(x_next);
				end
			end
			if (cmd.row_end) begin
				x_q <= WW'(entry_q);
			end
			if (cmd.repaint) begin
				x_q <= x_next;
			end
			if (cmd.next_row) begin
				y_q <= y_q + WW'(1);
			end
		end
	end

	// The pixel at the current column is the neighbour read one step earlier.
	always_ff @(posedge clk) begin
		if (cmd.fill_first || cmd.fill_eval) begin
			cur_q <= rdval;
		end
	end

	// Result register, which frees the input side while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_color_q <= (type_q == pscan_pkg::REQ_READ) ? pscan_pkg::COLOR_W'(rdval) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_color = read_color_q;

	// Status back to the controller.
	always_comb begin
		status.clear_last   = (clr_q == AW'(DEPTH - 1));
		status.req_type     = type_q;
		status.fill_go      = closed_q && (left_q < right_q) && (top_q < bottom_q);
		status.x_last       = (x_next >= WW'(right_q));
		status.parity       = inside_q;
		status.repaint_last = (x_q == WW'(right_q));
		status.row_last     = ((y_q + WW'(1)) >= WW'(bottom_q));
		status.out_free     = !out_valid_q || out_ready;
	end

endmodule

>>> rtl/core/pscan_ctrl.sv
// Controller state machine that sequences clearing, pixel requests and the scanline fill.
module pscan_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pscan_pkg::status_t status,
	output pscan_pkg::cmd_t    cmd
);

	pscan_pkg::state_t state_q;
	pscan_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pscan_pkg::ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			pscan_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) begin
					state_next = pscan_pkg::ST_IDLE;
				end
			end
			pscan_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
				if (in_valid) begin
					state_next = pscan_pkg::ST_DECODE;
				end
			end
			pscan_pkg::ST_DECODE: begin
				unique case (status.req_type)
					pscan_pkg::REQ_WRITE: state_next = pscan_pkg::ST_WRITE;
					pscan_pkg::REQ_READ:  state_next = pscan_pkg::ST_READ;
					pscan_pkg::REQ_FILL: begin
						cmd.fill_init = 1'b1;
						state_next    = status.fill_go ? pscan_pkg::ST_ROW_START
						                               : pscan_pkg::ST_FINISH;
					end
					default: state_next = pscan_pkg::ST_FINISH;
				endcase
			end
			pscan_pkg::ST_WRITE: begin
				cmd.pix_write = 1'b1;
				state_next    = pscan_pkg::ST_FINISH;
			end
			pscan_pkg::ST_READ: begin
				cmd.pix_read = 1'b1;
				state_next   = pscan_pkg::ST_FINISH;
			end
			pscan_pkg::ST_ROW_START: begin
				cmd.row_start = 1'b1;
				state_next    = pscan_pkg::ST_FILL_FIRST;
			end
			pscan_pkg::ST_FILL_FIRST: begin
				cmd.fill_first = 1'b1;
				state_next     = pscan_pkg::ST_FILL_EVAL;
			end
			pscan_pkg::ST_FILL_READ: begin
				cmd.fill_read = 1'b1;
				state_next    = pscan_pkg::ST_FILL_EVAL;
			end
			pscan_pkg::ST_FILL_EVAL: begin
				cmd.fill_eval = 1'b1;
				state_next    = status.x_last ? pscan_pkg::ST_ROW_END : pscan_pkg::ST_FILL_READ;
			end
			pscan_pkg::ST_ROW_END: begin
				if (status.parity) begin
					cmd.row_end = 1'b1;
					state_next  = pscan_pkg::ST_REPAINT;
				end else begin
					cmd.next_row = 1'b1;
					state_next   = status.row_last ? pscan_pkg::ST_FINISH
					                               : pscan_pkg::ST_ROW_START;
				end
			end
			pscan_pkg::ST_REPAINT: begin
				cmd.repaint = 1'b1;
				if (status.repaint_last) begin
					cmd.next_row = 1'b1;
					state_next   = status.row_last ? pscan_pkg::ST_FINISH
					                               : pscan_pkg::ST_ROW_START;
				end
			end
			pscan_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_next   = pscan_pkg::ST_IDLE;
				end
			end
			default: state_next = pscan_pkg::ST_CLEAR;
		endcase
	end

endmodule

>>> rtl/core/parity_scanline_fill_core.sv
// Top level of the parity scanline fill core: framebuffer with pixel and fill requests.
//
//   Channel   Handshake              Carries
//   input     in_valid / in_ready    req_type, pixel_x, pixel_y, color_value, box fields,
//                                    outline_closed
//   output    out_valid / out_ready  read_color, request_done
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data (outline and background codes)
//
// A pixel read or write passes from decode to its access state and then to finish, where its
// result is loaded once the output register is free.
// A fill reads and evaluates each box pixel, row by row, through the single read port of the
// frame memory, and repaints to background from the last entry column when a row ends inside.
// After reset the frame memory is swept to zero over all FRAME_HEIGHT * 2**clog2(FRAME_WIDTH)
// addresses, and no item is taken until the sweep ends; configuration writes are always taken.
// A new item is taken while an earlier result still waits in the output register.
module parity_scanline_fill_core #(
	parameter int FRAME_WIDTH  = pscan_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = pscan_pkg::FRAME_HEIGHT_DEF,
	parameter int COLOR_BITS   = pscan_pkg::COLOR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pscan_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pscan_pkg::CODE_W-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pscan_pkg::REQ_W-1:0]     req_type,
	input  logic [pscan_pkg::COORD_W-1:0]   pixel_x,
	input  logic [pscan_pkg::COORD_W-1:0]   pixel_y,
	input  logic [pscan_pkg::COLOR_W-1:0]   color_value,
	input  logic [pscan_pkg::BOX_W-1:0]     box_left,
	input  logic [pscan_pkg::BOX_W-1:0]     box_right,
	input  logic [pscan_pkg::BOX_W-1:0]     box_top,
	input  logic [pscan_pkg::BOX_W-1:0]     box_bottom,
	input  logic                            outline_closed,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pscan_pkg::COLOR_W-1:0]   read_color,
	output logic                            request_done
);

	pscan_pkg::cmd_t    cmd;
	pscan_pkg::status_t status;

	// Configuration writes are taken in any cycle.
	assign cfg_ready = 1'b1;

	// Every result marks a completed item.
	assign request_done = 1'b1;

	// Sequencer.
	pscan_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Frame memory and walk datapath.
	pscan_dp #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.COLOR_BITS   (COLOR_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.color_value    (color_value),
		.box_left       (box_left),
		.box_right      (box_right),
		.box_top        (box_top),
		.box_bottom     (box_bottom),
		.outline_closed (outline_closed),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.read_color     (read_color)
	);

endmodule
